[rtl/grid_maze_reachability_unit_macros.svh]
// assertion macros for the grid maze reachability unit
`ifndef GRID_MAZE_REACHABILITY_UNIT_MACROS_SVH
`define GRID_MAZE_REACHABILITY_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define GMR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define GMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gmr_pkg.sv]
// shared types and codes of the grid maze reachability unit
`timescale 1ns / 1ps
`default_nettype none
package gmr_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int LIM_W       = 7;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_LAST_ROW = 1'b0,
        REG_LAST_COL = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_CLR,
        ST_PRE0,
        ST_PRE1,
        ST_ROW,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/gmr_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module gmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/gmr_row_unit.sv]
// shared row update: one wave step of the flood on one grid row
`timescale 1ns / 1ps
`default_nettype none
module gmr_row_unit #(
    parameter int COLS = 16
) (
    input  wire logic [COLS-1:0] cur_row,
    input  wire logic [COLS-1:0] prev_row,
    input  wire logic [COLS-1:0] next_row,
    input  wire logic [COLS-1:0] blk_row,
    input  wire logic [COLS-1:0] col_mask,
    output logic      [COLS-1:0] new_row,
    output logic                 changed
);

    logic [COLS-1:0] grow;

    always_comb begin
        // spread to left, right, above and below, only into free in-bound cells
        grow    = (cur_row << 1) | (cur_row >> 1) | prev_row | next_row;
        new_row = cur_row | (grow & ~blk_row & col_mask);
        changed = (new_row != cur_row);
    end

endmodule
`default_nettype wire

[rtl/grid_maze_reachability_unit.sv]
// Grid maze reachability unit. A write beat (opcode 0) sets one cell's blocked bit by a
// read-modify-write of one grid row. A query beat (opcode 1) first clears the flood marks,
// then floods the grid from the start cell by repeated top-down sweeps of one shared row
// unit, one row per cycle, until a sweep adds nothing; it then loads the answer into the
// result register, waiting while an earlier answer is still unread. A start outside the
// grid or equal to the target skips the flood and answers not reachable. Input beats are
// taken while an answer waits; only the next answer is held back. After reset the grid
// store is cleared to free, row by row, in a pass during which no beat is taken;
// configuration writes are always taken and must be made only while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
module grid_maze_reachability_unit
    import gmr_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // opcode[0], row[4:1], col[8:5], blocked[9], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // reachable[0], zero fill
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_addr,
    input  wire logic [3:0]             cfg_wdata
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    state_t               state_reg, state_next;
    logic [3:0]           last_row_reg, last_col_reg;
    logic [RW-1:0]        row_reg, row_next;
    logic [CW-1:0]        col_reg, col_next;
    logic                 blk_reg, blk_next;
    logic [RW-1:0]        idx_reg, idx_next;
    logic [MAX_COLS-1:0]  cur_reg, cur_next, prev_reg, prev_next;
    logic                 chg_reg, chg_next;
    logic                 tgt_reg, tgt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_data_reg, m_data_next;

    logic [RW-1:0]        lr;
    logic [CW-1:0]        lc;
    logic [MAX_COLS-1:0]  col_mask;
    logic [LIM_W-1:0]     in_row, in_col, idx_p1, idx_p2;

    logic                 blk_we, rch_we;
    logic [RW-1:0]        blk_waddr, blk_raddr, rch_waddr, rch_raddr;
    logic [MAX_COLS-1:0]  blk_wdata, blk_rdata, rch_wdata, rch_rdata;

    logic [MAX_COLS-1:0]  next_row, new_row;
    logic                 row_changed;
    logic                 s_fire;

    // effective bounds, clamped to the store
    always_comb begin
        lr = (LIM_W'(last_row_reg) >= LIM_W'(MAX_ROWS)) ? RW'(MAX_ROWS - 1) : RW'(last_row_reg);
        lc = (LIM_W'(last_col_reg) >= LIM_W'(MAX_COLS)) ? CW'(MAX_COLS - 1) : CW'(last_col_reg);
        for (int k = 0; k < MAX_COLS; k++) begin
            col_mask[k] = (LIM_W'(k) <= LIM_W'(lc));
        end
    end

    assign in_row   = LIM_W'(s_tdata[4:1]);
    assign in_col   = LIM_W'(s_tdata[8:5]);
    assign idx_p1   = LIM_W'(idx_reg) + LIM_W'(1);
    assign idx_p2   = LIM_W'(idx_reg) + LIM_W'(2);
    assign s_fire   = s_tvalid && s_tready;
    assign next_row = (idx_reg < lr) ? rch_rdata : '0;

    gmr_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_blk_ram (
        .aclk  (aclk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    gmr_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_rch_ram (
        .aclk  (aclk),
        .we    (rch_we),
        .waddr (rch_waddr),
        .wdata (rch_wdata),
        .raddr (rch_raddr),
        .rdata (rch_rdata)
    );

    gmr_row_unit #(.COLS(MAX_COLS)) u_row (
        .cur_row  (cur_reg),
        .prev_row (prev_reg),
        .next_row (next_row),
        .blk_row  (blk_rdata),
        .col_mask (col_mask),
        .new_row  (new_row),
        .changed  (row_changed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            last_row_reg <= 4'd15;
            last_col_reg <= 4'd15;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index_t'(cfg_addr))
                    REG_LAST_ROW: last_row_reg <= cfg_wdata;
                    REG_LAST_COL: last_col_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        row_reg    <= row_next;
        col_reg    <= col_next;
        blk_reg    <= blk_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        chg_reg    <= chg_next;
        tgt_reg    <= tgt_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        blk_next     = blk_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        chg_next     = chg_reg;
        tgt_next     = tgt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        s_tready     = 1'b0;
        blk_we       = 1'b0;
        blk_waddr    = idx_reg;
        blk_wdata    = '0;
        blk_raddr    = row_reg;
        rch_we       = 1'b0;
        rch_waddr    = idx_reg;
        rch_wdata    = '0;
        rch_raddr    = '0;

        case (state_reg)
            ST_INIT: begin
                blk_we = 1'b1;
                if (LIM_W'(idx_reg) == LIM_W'(MAX_ROWS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    row_next = RW'(in_row);
                    col_next = CW'(in_col);
                    blk_next = s_tdata[9];
                    idx_next = '0;
                    if (opcode_t'(s_tdata[0]) == OP_WRITE) begin
                        if (in_row < LIM_W'(MAX_ROWS) && in_col < LIM_W'(MAX_COLS)) begin
                            state_next = ST_WR_RD;
                        end
                    end else if (in_row > LIM_W'(lr) || in_col > LIM_W'(lc) ||
                                 (in_row == LIM_W'(lr) && in_col == LIM_W'(lc))) begin
                        tgt_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CLR;
                    end
                end
            end
            ST_WR_RD: begin
                state_next = ST_WR_WB;
            end
            ST_WR_WB: begin
                blk_we             = 1'b1;
                blk_waddr          = row_reg;
                blk_wdata          = blk_rdata;
                blk_wdata[col_reg] = blk_reg;
                state_next         = ST_IDLE;
            end
            ST_CLR: begin
                // wipe the flood marks, seeding the start cell
                rch_we = 1'b1;
                if (idx_reg == row_reg) begin
                    rch_wdata[col_reg] = 1'b1;
                end
                if (idx_reg == lr) begin
                    state_next = ST_PRE0;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            ST_PRE0: begin
                rch_raddr  = '0;
                idx_next   = '0;
                chg_next   = 1'b0;
                state_next = ST_PRE1;
            end
            ST_PRE1: begin
                cur_next   = rch_rdata;
                prev_next  = '0;
                rch_raddr  = (idx_p1 >= LIM_W'(MAX_ROWS)) ? '0 : RW'(idx_p1);
                blk_raddr  = idx_reg;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                rch_we    = 1'b1;
                rch_wdata = new_row;
                prev_next = new_row;
                cur_next  = next_row;
                rch_raddr = (idx_p2 >= LIM_W'(MAX_ROWS)) ? '0 : RW'(idx_p2);
                blk_raddr = (idx_p1 >= LIM_W'(MAX_ROWS)) ? '0 : RW'(idx_p1);
                if (idx_reg == lr) begin
                    tgt_next = new_row[lc];
                    if (chg_reg || row_changed) begin
                        state_next = ST_PRE0;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    chg_next = chg_reg || row_changed;
                    idx_next = idx_reg + RW'(1);
                end
            end
            ST_DONE: begin
                // wait here while an earlier answer is still unread
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tgt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(OUT_TDATA_W - 1){1'b0}}, m_data_reg};

endmodule
`default_nettype wire

[rtl/gmr_checker.sv]
// port-level checks of the grid maze reachability unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "grid_maze_reachability_unit_macros.svh"
module gmr_checker
    import gmr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready
);

    `GMR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `GMR_ASSERT_NOW(a_out_fill, aclk, aresetn, m_tvalid, m_tdata[OUT_TDATA_W-1:1] == '0, "result fill bits not zero")
    `GMR_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_tvalid && s_tready, !s_tready, "beat taken while previous still in work")
    `GMR_ASSERT_NEXT(a_query_quiet, aclk, aresetn, s_tvalid && s_tready && s_tdata[0], !m_tvalid || $past(m_tvalid && !m_tready), "result appeared without work")

endmodule

bind grid_maze_reachability_unit gmr_checker u_gmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

[dv/grid_maze_reachability_unit_checker.sv]
// checker for the grid maze reachability unit: tracks grid and bounds, predicts answers
`timescale 1ns / 1ps
`default_nettype none
module grid_maze_reachability_unit_checker
    import gmr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic                   cfg_addr,
    input  wire logic [3:0]             cfg_wdata,
    output int                          fail_count,
    output int                          answers_pending
);
    logic       blocked_map [16][16];
    logic [3:0] bound_row;
    logic [3:0] bound_col;
    logic       answer_q [$];

    assign answers_pending = answer_q.size();

    // breadth-first flood from the start, start never re-entered
    function automatic logic reach_target(input logic [3:0] sr, input logic [3:0] sc);
        logic seen [16][16];
        int   wave_r [256];
        int   wave_c [256];
        int   head, tail;
        int   r, c, nr, nc, k;
        if (sr > bound_row || sc > bound_col || (sr == bound_row && sc == bound_col))
            return 1'b0;
        foreach (seen[i, j]) seen[i][j] = 1'b0;
        seen[sr][sc] = 1'b1;
        wave_r[0] = int'(sr);
        wave_c[0] = int'(sc);
        head = 0;
        tail = 1;
        while (head < tail) begin
            r = wave_r[head];
            c = wave_c[head];
            head++;
            for (k = 0; k < 4; k++) begin
                nr = r;
                nc = c;
                case (k)
                    0: nc = c - 1;
                    1: nc = c + 1;
                    2: nr = r - 1;
                    default: nr = r + 1;
                endcase
                if (nr < 0 || nc < 0 || nr > bound_row || nc > bound_col) continue;
                if (blocked_map[nr][nc] || seen[nr][nc]) continue;
                if (nr == bound_row && nc == bound_col) return 1'b1;
                seen[nr][nc] = 1'b1;
                wave_r[tail] = nr;
                wave_c[tail] = nc;
                tail++;
            end
        end
        return 1'b0;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            bound_row <= 4'd15;
            bound_col <= 4'd15;
            foreach (blocked_map[i, j]) blocked_map[i][j] <= 1'b0;
            answer_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == REG_LAST_ROW) bound_row <= cfg_wdata;
                else bound_col <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (opcode_t'(s_tdata[0]) == OP_WRITE)
                    blocked_map[s_tdata[4:1]][s_tdata[8:5]] <= s_tdata[9];
                else
                    answer_q.insert(answer_q.size(), reach_target(s_tdata[4:1], s_tdata[8:5]));
            end
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    report("answer beat with nothing expected");
                end else if (m_tdata[0] !== answer_q[0]) begin
                    report($sformatf("reachable got %0b expected %0b", m_tdata[0], answer_q[0]));
                    void'(answer_q.pop_front());
                end else begin
                    void'(answer_q.pop_front());
                end
            end
        end
    end
endmodule
`default_nettype wire

[dv/grid_maze_reachability_unit_test.sv]
// testbench top for the grid maze reachability unit: stimulus, pacing and verdict
`timescale 1ns / 1ps
`default_nettype none
module grid_maze_reachability_unit_test;
    import gmr_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_addr = 1'b0;
    logic [3:0]             cfg_wdata = '0;
    int                     fail_count;
    int                     answers_pending;
    int                     cycle_count = 0;
    bit                     hold_sink = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    grid_maze_reachability_unit u_top (.*);

    grid_maze_reachability_unit_checker u_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 20000000) begin
            $display("grid_maze_reachability_unit_test failed");
            $finish;
        end
    end

    // sink pacing: random gaps, with one long hold-off stretch
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_sink && !held) begin
                m_tready <= 1'b0;
                repeat (2000) @(posedge aclk);
                held = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_beat(input opcode_t op, input logic [3:0] r, input logic [3:0] c,
                             input logic blk, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {6'd0, blk, c, r, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_bounds(input logic [3:0] lr, input logic [3:0] lc);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        // a trailing cell write may still be in flight
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= REG_LAST_ROW;
        cfg_wdata <= lr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_addr  <= REG_LAST_COL;
        cfg_wdata <= lc;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic maze_phase(input logic [3:0] lr, input logic [3:0] lc, input int n,
                              input bit fast);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0)
                send_beat(OP_QUERY, 4'($urandom_range(0, lr)), 4'($urandom_range(0, lc)),
                          1'($urandom_range(0, 1)), fast);
            else if ($urandom_range(0, 9) == 0)
                send_beat(opcode_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), fast);
            else
                send_beat(OP_WRITE, 4'($urandom_range(0, lr)), 4'($urandom_range(0, lc)),
                          $urandom_range(0, 3) == 0, fast);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: corners, start on target, out of grid, blocked start and target
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        send_beat(OP_QUERY, 4'd15, 4'd15, 1'b1, 1'b0);
        send_beat(OP_QUERY, 4'd15, 4'd14, 1'b0, 1'b0);
        send_beat(OP_WRITE, 4'd0, 4'd0, 1'b1, 1'b0);
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        send_beat(OP_WRITE, 4'd15, 4'd15, 1'b1, 1'b0);
        send_beat(OP_QUERY, 4'd3, 4'd7, 1'b0, 1'b0);
        send_beat(OP_WRITE, 4'd15, 4'd15, 1'b0, 1'b0);
        send_beat(OP_WRITE, 4'd14, 4'd15, 1'b1, 1'b0);
        send_beat(OP_WRITE, 4'd15, 4'd14, 1'b1, 1'b0);
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        send_beat(OP_QUERY, 4'd14, 4'd15, 1'b0, 1'b0);
        write_bounds(4'd3, 4'd2);
        send_beat(OP_QUERY, 4'd4, 4'd0, 1'b0, 1'b0);
        send_beat(OP_QUERY, 4'd0, 4'd3, 1'b0, 1'b0);
        send_beat(OP_QUERY, 4'd3, 4'd2, 1'b0, 1'b0);
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        write_bounds(4'd0, 4'd0);
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        write_bounds(4'd0, 4'd5);
        send_beat(OP_QUERY, 4'd0, 4'd0, 1'b0, 1'b0);
        // random phases across bound settings, one with a long sink hold-off
        write_bounds(4'd3, 4'd3);
        hold_sink = 1'b1;
        maze_phase(4'd3, 4'd3, 60, 1'b1);
        write_bounds(4'd15, 4'd15);
        maze_phase(4'd15, 4'd15, 130, 1'b0);
        write_bounds(4'd7, 4'd4);
        maze_phase(4'd7, 4'd4, 100, 1'b0);
        write_bounds(4'd1, 4'd15);
        maze_phase(4'd1, 4'd15, 80, 1'b0);
        write_bounds(4'd15, 4'd0);
        maze_phase(4'd15, 4'd0, 60, 1'b0);
        write_bounds(4'd5, 4'd5);
        maze_phase(4'd5, 4'd5, 80, 1'b0);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("grid_maze_reachability_unit_test passed");
        else
            $display("grid_maze_reachability_unit_test failed");
        $finish;
    end
endmodule
`default_nettype wire
